// ----- src/bsr_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the byte stack
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;

    localparam int DEPTH  = 64;
    localparam int A_W    = $clog2(DEPTH);
    localparam int C_W    = $clog2(DEPTH + 1);
    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;
    localparam int KIND_W = 3;
    localparam int CAP_W  = 7;
    localparam int SPAN_W = 7;
    localparam int CMP_W  = (C_W > CAP_W) ? ((C_W > SPAN_W) ? C_W : SPAN_W)
                                          : ((CAP_W > SPAN_W) ? CAP_W : SPAN_W);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_PEEK = 3'd2,
        OP_DUP  = 3'd3,
        OP_UP   = 3'd4,
        OP_DOWN = 3'd5,
        OP_LIST = 3'd6
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FULL       = 3'd0,
        KIND_EMPTY      = 3'd1,
        KIND_TOP        = 3'd2,
        KIND_ENTRY      = 3'd3,
        KIND_EMPTY_LIST = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_START,
        PTR_STEP
    } ptr_sel_t;

    typedef enum logic [1:0] {
        RD_TOP,
        RD_START,
        RD_STEP
    } rd_sel_t;

    typedef enum logic {
        WA_CNT,
        WA_PTR
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_VAL,
        WD_RDATA,
        WD_TMP
    } wd_sel_t;

    typedef struct packed {
        logic     load;
        logic     cnt_inc;
        logic     cnt_dec;
        ptr_sel_t ptr_sel;
        logic     re;
        rd_sel_t  rd_sel;
        logic     we;
        wa_sel_t  wa_sel;
        wd_sel_t  wd_sel;
        logic     tmp_load;
        logic     emit;
        kind_t    kind;
        logic     byte_from_ram;
        logic     last;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            span_ok;
        logic            step_is_end;
        logic            ptr_is_zero;
    } stat_t;

endpackage
`default_nettype wire

// ----- src/bsr_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- src/bsr_datapath.sv -----
// stack datapath: count, pointer, entry ram, capacity register and result registers
`timescale 1ns / 1ps
`default_nettype none
module bsr_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bsr_pkg::OP_W-1:0]      operation,
    input  wire logic [bsr_pkg::BYTE_W-1:0]    push_value,
    input  wire logic [bsr_pkg::SPAN_W-1:0]    rotate_span,
    input  wire logic                          cfg_write,
    input  wire logic [bsr_pkg::CAP_W-1:0]     cfg_data,
    input  wire bsr_pkg::cmd_t                 cmd,
    output      bsr_pkg::stat_t                stat,
    output      logic                          result_valid,
    output      logic [bsr_pkg::KIND_W-1:0]    result_kind,
    output      logic [bsr_pkg::BYTE_W-1:0]    result_byte,
    output      logic                          last_of_run
);

    logic [bsr_pkg::C_W-1:0]    cnt_reg, cnt_next;
    logic [bsr_pkg::A_W-1:0]    ptr_reg, ptr_next;
    logic [bsr_pkg::CAP_W-1:0]  cap_reg;
    logic [bsr_pkg::OP_W-1:0]   op_reg;
    logic [bsr_pkg::BYTE_W-1:0] val_reg;
    logic [bsr_pkg::SPAN_W-1:0] span_reg;
    logic [bsr_pkg::BYTE_W-1:0] tmp_reg;
    logic                       valid_reg;
    logic [bsr_pkg::KIND_W-1:0] kind_reg;
    logic [bsr_pkg::BYTE_W-1:0] byte_reg;
    logic                       last_reg;

    logic [bsr_pkg::CMP_W-1:0]  cnt_ext, cap_ext, cap_eff, span_ext, depth_ext;
    logic [bsr_pkg::A_W-1:0]    top_addr, low_addr, start_addr, end_addr, step_addr;
    logic [bsr_pkg::A_W-1:0]    raddr, waddr;
    logic [bsr_pkg::BYTE_W-1:0] wdata, rdata;
    logic                       is_down;

    assign cnt_ext   = bsr_pkg::CMP_W'(cnt_reg);
    assign cap_ext   = bsr_pkg::CMP_W'(cap_reg);
    assign span_ext  = bsr_pkg::CMP_W'(span_reg);
    assign depth_ext = bsr_pkg::CMP_W'(bsr_pkg::DEPTH);
    assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;

    assign top_addr  = bsr_pkg::A_W'(cnt_reg - bsr_pkg::C_W'(1));
    assign low_addr  = bsr_pkg::A_W'(cnt_ext - span_ext);
    assign is_down   = (op_reg == bsr_pkg::OP_DOWN);
    // up rotate walks from the top down, down rotate from the low end up
    assign start_addr = is_down ? low_addr : top_addr;
    assign end_addr   = is_down ? top_addr : low_addr;
    assign step_addr  = is_down ? (ptr_reg + bsr_pkg::A_W'(1)) : (ptr_reg - bsr_pkg::A_W'(1));

    assign stat.op          = op_reg;
    assign stat.full        = (cnt_ext >= cap_eff);
    assign stat.empty       = (cnt_reg == '0);
    assign stat.span_ok     = (span_ext >= bsr_pkg::CMP_W'(2)) && (span_ext <= cnt_ext);
    assign stat.step_is_end = (step_addr == end_addr);
    assign stat.ptr_is_zero = (ptr_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + bsr_pkg::C_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - bsr_pkg::C_W'(1);
        end

        case (cmd.ptr_sel)
            bsr_pkg::PTR_TOP:   ptr_next = top_addr;
            bsr_pkg::PTR_START: ptr_next = start_addr;
            bsr_pkg::PTR_STEP:  ptr_next = step_addr;
            default:            ptr_next = ptr_reg;
        endcase

        case (cmd.rd_sel)
            bsr_pkg::RD_START: raddr = start_addr;
            bsr_pkg::RD_STEP:  raddr = step_addr;
            default:           raddr = top_addr;
        endcase

        // a push or dup only writes below the capacity, so the count fits the address
        waddr = (cmd.wa_sel == bsr_pkg::WA_CNT) ? bsr_pkg::A_W'(cnt_reg) : ptr_reg;

        case (cmd.wd_sel)
            bsr_pkg::WD_RDATA: wdata = rdata;
            bsr_pkg::WD_TMP:   wdata = tmp_reg;
            default:           wdata = val_reg;
        endcase
    end

    bsr_ram #(
        .WIDTH (bsr_pkg::BYTE_W),
        .DEPTH (bsr_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            cap_reg   <= bsr_pkg::CAP_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= cmd.emit;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        kind_reg <= cmd.kind;
        byte_reg <= cmd.byte_from_ram ? rdata : '0;
        last_reg <= cmd.last;
        if (cmd.load)
        begin
            op_reg   <= operation;
            val_reg  <= push_value;
            span_reg <= rotate_span;
        end
        if (cmd.tmp_load)
        begin
            tmp_reg <= rdata;
        end
    end

    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign result_byte  = byte_reg;
    assign last_of_run  = last_reg;

endmodule
`default_nettype wire

// ----- src/bsr_ctrl.sv -----
// stack controller: sequences each request through ram reads, writes and results
`timescale 1ns / 1ps
`default_nettype none
module bsr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output      logic           busy,
    input  wire bsr_pkg::stat_t stat,
    output      bsr_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK_OUT,
        S_DUP_WR,
        S_ROT_LOAD,
        S_ROT_WR,
        S_ROT_RD,
        S_ROT_LAST,
        S_LIST
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next        = state_reg;
        cmd.load          = 1'b0;
        cmd.cnt_inc       = 1'b0;
        cmd.cnt_dec       = 1'b0;
        cmd.ptr_sel       = bsr_pkg::PTR_HOLD;
        cmd.re            = 1'b0;
        cmd.rd_sel        = bsr_pkg::RD_TOP;
        cmd.we            = 1'b0;
        cmd.wa_sel        = bsr_pkg::WA_CNT;
        cmd.wd_sel        = bsr_pkg::WD_VAL;
        cmd.tmp_load      = 1'b0;
        cmd.emit          = 1'b0;
        cmd.kind          = bsr_pkg::KIND_FULL;
        cmd.byte_from_ram = 1'b0;
        cmd.last          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (stat.op)
                    bsr_pkg::OP_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = bsr_pkg::KIND_FULL;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.we      = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    bsr_pkg::OP_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = bsr_pkg::KIND_EMPTY;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                    end
                    bsr_pkg::OP_PEEK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = bsr_pkg::KIND_EMPTY;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.re     = 1'b1;
                            state_next = S_PEEK_OUT;
                        end
                    end
                    bsr_pkg::OP_DUP:
                    begin
                        // full wins over empty when the capacity is zero
                        if (stat.full)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = bsr_pkg::KIND_FULL;
                            cmd.last = 1'b1;
                        end
                        else if (stat.empty)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = bsr_pkg::KIND_EMPTY;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.re     = 1'b1;
                            state_next = S_DUP_WR;
                        end
                    end
                    bsr_pkg::OP_UP, bsr_pkg::OP_DOWN:
                    begin
                        // a span of one changes nothing, so only spans of two or more, up to the count, run
                        if (stat.span_ok)
                        begin
                            cmd.re      = 1'b1;
                            cmd.rd_sel  = bsr_pkg::RD_START;
                            cmd.ptr_sel = bsr_pkg::PTR_START;
                            state_next  = S_ROT_LOAD;
                        end
                    end
                    bsr_pkg::OP_LIST:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = bsr_pkg::KIND_EMPTY_LIST;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.re      = 1'b1;
                            cmd.ptr_sel = bsr_pkg::PTR_TOP;
                            state_next  = S_LIST;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PEEK_OUT:
            begin
                cmd.emit          = 1'b1;
                cmd.kind          = bsr_pkg::KIND_TOP;
                cmd.byte_from_ram = 1'b1;
                cmd.last          = 1'b1;
                state_next        = S_IDLE;
            end
            S_DUP_WR:
            begin
                cmd.we      = 1'b1;
                cmd.wd_sel  = bsr_pkg::WD_RDATA;
                cmd.cnt_inc = 1'b1;
                state_next  = S_IDLE;
            end
            S_ROT_LOAD:
            begin
                cmd.tmp_load = 1'b1;
                cmd.re       = 1'b1;
                cmd.rd_sel   = bsr_pkg::RD_STEP;
                state_next   = S_ROT_WR;
            end
            S_ROT_WR:
            begin
                // move the neighbor into the pointer slot, then step toward the far end
                cmd.we      = 1'b1;
                cmd.wa_sel  = bsr_pkg::WA_PTR;
                cmd.wd_sel  = bsr_pkg::WD_RDATA;
                cmd.ptr_sel = bsr_pkg::PTR_STEP;
                state_next  = stat.step_is_end ? S_ROT_LAST : S_ROT_RD;
            end
            S_ROT_RD:
            begin
                cmd.re     = 1'b1;
                cmd.rd_sel = bsr_pkg::RD_STEP;
                state_next = S_ROT_WR;
            end
            S_ROT_LAST:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = bsr_pkg::WA_PTR;
                cmd.wd_sel = bsr_pkg::WD_TMP;
                state_next = S_IDLE;
            end
            S_LIST:
            begin
                // emit the entry read last cycle while reading the one below it
                cmd.emit          = 1'b1;
                cmd.kind          = bsr_pkg::KIND_ENTRY;
                cmd.byte_from_ram = 1'b1;
                if (stat.ptr_is_zero)
                begin
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.re      = 1'b1;
                    cmd.rd_sel  = bsr_pkg::RD_STEP;
                    cmd.ptr_sel = bsr_pkg::PTR_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

// ----- src/byte_stack_with_rotate.sv -----
// top level of the byte stack with rotate: controller plus datapath
//
//  channel   signals                                      handshake
//  --------  -------------------------------------------  ------------------------
//  request   operation, push_value, rotate_span           start high, busy low
//  result    result_kind, result_byte, last_of_run        result_valid, one cycle
//  config    cfg_data (capacity)                          cfg_write
//
// the registered ram read shapes each request: each moved entry is read, then
// written back, and a listing reads each entry before it is shown. busy is low
// while the controller is idle, and a request with start high is taken there.
// a result is registered and shows in the cycle after the one that produces it; a
// listing streams one entry per cycle. the receiver cannot stall; reset clears the
// count and sets the capacity to 64 at once, the entry ram needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module byte_stack_with_rotate (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output      logic                       busy,
    input  wire logic [bsr_pkg::OP_W-1:0]   operation,
    input  wire logic [bsr_pkg::BYTE_W-1:0] push_value,
    input  wire logic [bsr_pkg::SPAN_W-1:0] rotate_span,
    input  wire logic                       cfg_write,
    input  wire logic [bsr_pkg::CAP_W-1:0]  cfg_data,
    output      logic                       result_valid,
    output      logic [bsr_pkg::KIND_W-1:0] result_kind,
    output      logic [bsr_pkg::BYTE_W-1:0] result_byte,
    output      logic                       last_of_run
);

    bsr_pkg::cmd_t  cmd;
    bsr_pkg::stat_t stat;

    bsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    bsr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (operation),
        .push_value   (push_value),
        .rotate_span  (rotate_span),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .result_byte  (result_byte),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire

// ----- tb/sv/byte_stack_with_rotate_tb.sv -----
// self-checking testbench for the byte stack with rotate: driver, monitor and stack predictor
`timescale 1ns / 1ps
module byte_stack_with_rotate_tb;
    import bsr_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 3'd7;   // unused code, ignored by the block
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 140;          // covers the longest busy stretch: rotate of 64 entries

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] value;
        logic [SPAN_W-1:0] span;
    } request_t;

    typedef struct {
        kind_t             kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [OP_W-1:0]   operation = '0;
    logic [BYTE_W-1:0] push_value = '0;
    logic [SPAN_W-1:0] rotate_span = '0;
    logic              cfg_write = 1'b0;
    logic [CAP_W-1:0]  cfg_data = '0;
    wire               busy;
    wire               result_valid;
    wire [KIND_W-1:0]  result_kind;
    wire [BYTE_W-1:0]  result_byte;
    wire               last_of_run;

    byte_stack_with_rotate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .push_value   (push_value),
        .rotate_span  (rotate_span),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .result_byte  (result_byte),
        .last_of_run  (last_of_run)
    );

    request_t request_queue[$];
    outcome_t due_results[$];

    // predicted stack contents and setting
    logic [BYTE_W-1:0] stack_mem [DEPTH];
    int                stack_depth = 0;
    int                cap_setting = 64;

    // depth as the stimulus planner expects it, used to aim rotate spans
    int                plan_depth = 0;
    int                plan_cap = 64;

    int                error_count = 0;
    int                cycle_count = 0;
    bit                gap_free = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic apply_request(input request_t rq);
        outcome_t          run[$];
        int                eff;
        int                cnt;
        int                span;
        int                i;
        logic [BYTE_W-1:0] carry;
        eff = (cap_setting > DEPTH) ? DEPTH : cap_setting;
        cnt = stack_depth;
        span = rq.span;
        case (rq.op)
            OP_PUSH:
                if (cnt >= eff)
                    run.push_back('{KIND_FULL, 8'h00, 1'b0});
                else
                begin
                    stack_mem[cnt] = rq.value;
                    stack_depth = cnt + 1;
                end
            OP_POP:
                if (cnt == 0)
                    run.push_back('{KIND_EMPTY, 8'h00, 1'b0});
                else
                    stack_depth = cnt - 1;
            OP_PEEK:
                if (cnt == 0)
                    run.push_back('{KIND_EMPTY, 8'h00, 1'b0});
                else
                    run.push_back('{KIND_TOP, stack_mem[cnt-1], 1'b0});
            OP_DUP:
                // full wins over empty when the capacity is zero
                if (cnt >= eff)
                    run.push_back('{KIND_FULL, 8'h00, 1'b0});
                else if (cnt == 0)
                    run.push_back('{KIND_EMPTY, 8'h00, 1'b0});
                else
                begin
                    stack_mem[cnt] = stack_mem[cnt-1];
                    stack_depth = cnt + 1;
                end
            OP_UP:
                if (span != 0 && span <= cnt)
                begin
                    carry = stack_mem[cnt-1];
                    for (i = cnt - 1; i > cnt - span; i--)
                        stack_mem[i] = stack_mem[i-1];
                    stack_mem[cnt-span] = carry;
                end
            OP_DOWN:
                if (span != 0 && span <= cnt)
                begin
                    carry = stack_mem[cnt-span];
                    for (i = cnt - span; i + 1 < cnt; i++)
                        stack_mem[i] = stack_mem[i+1];
                    stack_mem[cnt-1] = carry;
                end
            OP_LIST:
                if (cnt == 0)
                    run.push_back('{KIND_EMPTY_LIST, 8'h00, 1'b0});
                else
                    for (i = cnt; i > 0; i--)
                        run.push_back('{KIND_ENTRY, stack_mem[i-1], 1'b0});
            default:
                ;
        endcase
        if (run.size() != 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[k])
            due_results.push_back(run[k]);
    endtask

    // queue one request and track the depth it leads to
    task automatic plan(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] value,
                        input logic [SPAN_W-1:0] span);
        int eff;
        eff = (plan_cap > DEPTH) ? DEPTH : plan_cap;
        if (op == OP_PUSH && plan_depth < eff)
            plan_depth++;
        else if (op == OP_POP && plan_depth > 0)
            plan_depth--;
        else if (op == OP_DUP && plan_depth > 0 && plan_depth < eff)
            plan_depth++;
        request_queue.push_back('{op, value, span});
    endtask

    task automatic plan_random(input int count, input int push_pct);
        logic [OP_W-1:0]   op;
        logic [SPAN_W-1:0] span;
        int                roll;
        int                placed;
        placed = 0;
        while (placed < count)
        begin
            roll = $urandom_range(99);
            if (roll < push_pct)
                op = OP_PUSH;
            else
            begin
                roll = $urandom_range(99);
                if (roll < 18)      op = OP_POP;
                else if (roll < 32) op = OP_PEEK;
                else if (roll < 46) op = OP_DUP;
                else if (roll < 64) op = OP_UP;
                else if (roll < 82) op = OP_DOWN;
                else if (roll < 96) op = OP_LIST;
                else                op = OP_NONE;
            end
            span = SPAN_W'($urandom_range(127));
            if (op == OP_UP || op == OP_DOWN)
            begin
                roll = $urandom_range(99);
                if (roll < 75 && plan_depth > 1)
                    span = SPAN_W'($urandom_range(plan_depth, 2));
                else if (roll < 88)
                    span = SPAN_W'($urandom_range(plan_depth + 1, 0));
            end
            plan(op, BYTE_W'($urandom_range(255)), span);
            if (op != OP_NONE)
                placed++;
        end
    endtask

    // block is quiet: no request waiting, no result due, then a pause for silent work
    task automatic wait_quiet();
        @(posedge clk);
        while (request_queue.size() != 0 || start || busy || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        cap_setting = value;
        plan_cap = value;
    endtask

    // request driver
    request_t live_rq;
    int       idle_left = 0;
    int       gap_roll;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            if (start && !busy)
                apply_request(live_rq);
            if (start && busy)
                ;
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (request_queue.size() != 0)
            begin
                live_rq = request_queue.pop_front();
                operation <= live_rq.op;
                push_value <= live_rq.value;
                rotate_span <= live_rq.span;
                start <= 1'b1;
                gap_roll = $urandom_range(99);
                if (gap_free || gap_roll < 50)
                    idle_left = 0;
                else if (gap_roll < 88)
                    idle_left = $urandom_range(3, 1);
                else
                    idle_left = $urandom_range(40, 8);
            end
            else
                start <= 1'b0;
        end
    end

    // result monitor
    outcome_t want;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (due_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none expected: kind %0d byte %02h last %0b",
                         $time, result_kind, result_byte, last_of_run);
            end
            else
            begin
                want = due_results.pop_front();
                if (result_kind !== want.kind)
                begin
                    error_count++;
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, want.kind, result_kind);
                end
                if (result_byte !== want.value)
                begin
                    error_count++;
                    $display("%0t: result_byte expected %02h actual %02h",
                             $time, want.value, result_byte);
                end
                if (last_of_run !== want.last)
                begin
                    error_count++;
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want.last, last_of_run);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack cases at the reset capacity
        plan(OP_PEEK, 8'h00, 7'd0);
        plan(OP_POP, 8'h00, 7'd0);
        plan(OP_DUP, 8'h00, 7'd0);
        plan(OP_LIST, 8'h00, 7'd0);
        plan(OP_UP, 8'h00, 7'd0);
        plan(OP_NONE, 8'hff, 7'd127);
        // small stack: rotates with spans that fit, a span of one and spans beyond the count
        plan(OP_PUSH, 8'h00, 7'd0);
        plan(OP_PUSH, 8'hff, 7'd0);
        plan(OP_PUSH, 8'h5a, 7'd0);
        plan(OP_DUP, 8'h00, 7'd0);
        plan(OP_PEEK, 8'h00, 7'd0);
        plan(OP_UP, 8'h00, 7'd3);
        plan(OP_LIST, 8'h00, 7'd0);
        plan(OP_DOWN, 8'h00, 7'd3);
        plan(OP_UP, 8'h00, 7'd1);
        plan(OP_UP, 8'h00, 7'd5);
        plan(OP_DOWN, 8'h00, 7'd127);
        plan(OP_LIST, 8'h00, 7'd0);
        wait_quiet();

        // capacity lowered below the count held
        set_capacity(7'd2);
        plan(OP_PUSH, 8'h33, 7'd0);
        plan(OP_DUP, 8'h00, 7'd0);
        repeat (5) plan(OP_POP, 8'h00, 7'd0);
        wait_quiet();

        // zero capacity: dup on an empty stack reports full
        set_capacity(7'd0);
        plan(OP_DUP, 8'h00, 7'd0);
        plan(OP_PUSH, 8'hc3, 7'd0);
        wait_quiet();

        // capacity above the store depth, fill toward the top
        set_capacity(7'd127);
        plan_random(80, 65);
        wait_quiet();

        // back-to-back requests at a capacity equal to the store depth
        set_capacity(7'd64);
        gap_free = 1'b1;
        plan_random(20, 70);
        wait_quiet();
        gap_free = 1'b0;

        set_capacity(7'd1);
        plan_random(30, 15);
        wait_quiet();

        set_capacity(7'd8);
        plan_random(30, 45);
        wait_quiet();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
